>>> hw/rtl/ssb_pkg.sv
// Package for the sortable stack buffer: codes, widths and constants.
`default_nettype none
package ssb_pkg;
  localparam int DEPTH_DEFAULT = 64;
  localparam int WORD_W = 32;
  localparam int CNT_W = 7;
  localparam int CAP_W = 8;
  localparam int IDX_W = 6;
  localparam int MODE_W = 4;
  localparam int TDATA_IN_W = 48;
  localparam int TDATA_OUT_W = 32;
  localparam int TUSER_OUT_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH = 4'd0;
  localparam logic [MODE_W-1:0] MODE_POP = 4'd1;
  localparam logic [MODE_W-1:0] MODE_FRONT = 4'd2;
  localparam logic [MODE_W-1:0] MODE_BACK = 4'd3;
  localparam logic [MODE_W-1:0] MODE_CAP = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SIZE = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ELEM = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SORT = 4'd7;
  localparam logic [MODE_W-1:0] MODE_REINIT = 4'd8;

  localparam logic [1:0] REG_INIT_CAP = 2'd0;
  localparam logic [1:0] REG_FILL_ON = 2'd1;
  localparam logic [1:0] REG_FILL_VAL = 2'd2;
endpackage
`default_nettype wire

>>> hw/rtl/sortable_stack_buffer.sv
// Top level of the sortable stack buffer: stack store, sequencer and sort.
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | s_axis_tvalid/tready   | tdata: mode[3:0], push_value[35:4],
//           |           |                        |        read_index[41:36] (48 bits)
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: value; tuser: valid_res, overflow;
//           |           |                        | tlast: last
//  cfg      | in        | cfg_we                 | cfg_index, cfg_data
//
// A request that needs no store read has its result registered in S_IDLE as it
// is accepted; S_OUT then presents it until it is taken. Front, back and
// element requests add a registered read of the store through S_READ and S_RESP.
// Sort is an insertion sort using one signed comparator and the store's one read
// port and one write port: each key is fetched through S_KEY and S_CMP, each
// shifted element passes S_SHIFT and S_PLACE, then each result is read in
// S_EMIT_RD and sent from S_EMIT. A filling reinit writes one entry per cycle,
// up to DEPTH entries. Reset is synchronous and clears the control state; the
// store itself is not cleared. The block takes no request until the previous
// result has been delivered.
`default_nettype none
module sortable_stack_buffer #(
  parameter int DEPTH = ssb_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode, push_value, read_index, from bit 0 up; padded to 48 bits
  input  wire logic [ssb_pkg::TDATA_IN_W-1:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // value
  output logic [ssb_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  // valid_res, overflow, from bit 0 up
  output logic [ssb_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ssb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_RESP, S_OUT, S_FILL,
    S_KEY, S_CMP, S_SHIFT, S_PLACE, S_EMIT_RD, S_EMIT
  } state_t;

  state_t state;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [AW-1:0] raddr;
  logic [CNT_W-1:0] fill_count;
  logic [CAP_W-1:0] capacity;
  logic [6:0] init_capacity;
  logic fill_on_init;
  logic [WORD_W-1:0] fill_value;
  logic [CNT_W-1:0] i_cnt, j_cnt;
  logic [WORD_W-1:0] key;
  logic rd_ok;

  // Signed compare: key below the word read from below it.
  logic key_less;
  assign key_less = $signed(key) < $signed(rdata);

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT_CAP: init_capacity <= cfg_data[6:0];
        REG_FILL_ON: fill_on_init <= cfg_data[0];
        REG_FILL_VAL: fill_value <= cfg_data;
        default: ;
      endcase
    end
    if (rst) begin
      init_capacity <= 7'd1;
      fill_on_init <= 1'b0;
      fill_value <= '0;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_count <= '0;
      capacity <= 8'd1;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            m_axis_tdata <= '0;
            m_axis_tuser <= 2'b00;
            m_axis_tlast <= 1'b1;
            state <= S_RESP;
            unique case (s_axis_tdata[3:0])
              MODE_PUSH: begin
                if (fill_count >= DEPTH_C) begin
                  m_axis_tuser <= 2'b10;
                end else begin
                  if ({1'b0, fill_count} == capacity) capacity <= {capacity[CAP_W-2:0], 1'b0};
                  mem[fill_count[AW-1:0]] <= s_axis_tdata[35:4];
                  fill_count <= fill_count + 1'b1;
                end
                state <= S_OUT;
              end
              MODE_POP: begin
                if (fill_count != '0) fill_count <= fill_count - 1'b1;
                state <= S_OUT;
              end
              MODE_FRONT: begin
                raddr <= '0; rd_ok <= fill_count != '0; state <= S_READ;
              end
              MODE_BACK: begin
                raddr <= AW'(fill_count - 1'b1); rd_ok <= fill_count != '0;
                state <= S_READ;
              end
              MODE_CAP: begin
                m_axis_tdata <= WORD_W'(capacity); m_axis_tuser <= 2'b01;
                state <= S_OUT;
              end
              MODE_SIZE: begin
                m_axis_tdata <= WORD_W'(fill_count); m_axis_tuser <= 2'b01;
                state <= S_OUT;
              end
              MODE_ELEM: begin
                raddr <= AW'(s_axis_tdata[41:36]);
                rd_ok <= CNT_W'(s_axis_tdata[41:36]) < fill_count;
                state <= S_READ;
              end
              MODE_SORT: begin
                if (fill_count == '0) begin
                  state <= S_OUT;
                end else begin
                  i_cnt <= CNT_W'(1);
                  state <= S_KEY;
                  raddr <= AW'(1);
                end
              end
              MODE_REINIT: begin
                capacity <= CAP_W'(init_capacity);
                if (fill_on_init && init_capacity != '0) begin
                  i_cnt <= '0;
                  state <= S_FILL;
                end else begin
                  fill_count <= '0;
                  state <= S_OUT;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_FILL: begin
          mem[i_cnt[AW-1:0]] <= fill_value;
          if (i_cnt + 1'b1 == init_capacity || i_cnt + 1'b1 == DEPTH_C) begin
            fill_count <= i_cnt + 1'b1;
            state <= S_OUT;
          end
          i_cnt <= i_cnt + 1'b1;
        end
        S_READ: state <= S_RESP;
        S_RESP: begin
          if (rd_ok) begin
            m_axis_tdata <= rdata; m_axis_tuser <= 2'b01;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        // Insertion sort: fetch key at i, then walk j down shifting.
        S_KEY: begin
          if (i_cnt >= fill_count) begin
            i_cnt <= '0; raddr <= '0; state <= S_EMIT_RD;
          end else begin
            state <= S_CMP;
            j_cnt <= i_cnt;
            raddr <= AW'(i_cnt - 1'b1);
          end
        end
        S_CMP: begin
          // rdata holds entry i this cycle
          key <= rdata;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // rdata holds entry j-1
          if (j_cnt != '0 && key_less) begin
            mem[j_cnt[AW-1:0]] <= rdata;
            j_cnt <= j_cnt - 1'b1;
            raddr <= AW'(j_cnt - 2'd2);
            state <= S_PLACE;
          end else begin
            mem[j_cnt[AW-1:0]] <= key;
            i_cnt <= i_cnt + 1'b1;
            raddr <= AW'(i_cnt + 1'b1);
            state <= S_KEY;
          end
        end
        S_PLACE: state <= S_SHIFT;
        S_EMIT_RD: begin
          // The previous result may be taken while the next entry is read.
          if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          // raddr stays on entry i until it is sent, so rdata holds it through a stall.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= rdata;
            m_axis_tuser <= 2'b01;
            m_axis_tlast <= (i_cnt + 1'b1 == fill_count);
            if (i_cnt + 1'b1 == fill_count) begin
              state <= S_OUT;
            end else begin
              i_cnt <= i_cnt + 1'b1;
              raddr <= AW'(i_cnt + 1'b1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> tb/tb_sortable_stack_buffer.sv
// Self-checking testbench for the sortable stack buffer: random and directed stack requests.
`timescale 1ns / 100ps
`default_nettype none
module tb_sortable_stack_buffer;
  import ssb_pkg::*;

  localparam int STORE_DEPTH = 64;

  // One request as the sender presents it.
  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] push_value;
    logic [5:0]  read_index;
  } stack_req_t;

  // One result as the block is expected to return it.
  typedef struct packed {
    logic [31:0] value;
    logic        valid_res;
    logic        overflow;
    logic        last;
  } stack_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // mode, push_value, read_index, from bit 0 up
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // value
  logic [31:0] m_axis_tdata;
  // valid_res, overflow, from bit 0 up
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sortable_stack_buffer dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block's state, kept by the stack predictor below.
  logic [31:0] shadow_store [STORE_DEPTH];
  int unsigned shadow_count;
  logic [7:0]  shadow_capacity;
  logic [6:0]  cfg_init_capacity;
  logic        cfg_fill_on;
  logic [31:0] cfg_fill_value;

  stack_req_t  pending_reqs [$];
  stack_resp_t expected_resps [$];
  int          error_count = 0;
  bit          sender_idle_allowed = 1'b1;
  bit          sink_stall_allowed = 1'b1;

  // Applies one request to the shadow state and queues the results it causes.
  task automatic predict_stack(input stack_req_t r);
    stack_resp_t rs;
    logic [31:0] key;
    int          j;
    int unsigned n;
    rs = '{value: '0, valid_res: 1'b0, overflow: 1'b0, last: 1'b1};
    case (r.mode)
      MODE_PUSH: begin
        if (shadow_count >= STORE_DEPTH) begin
          rs.overflow = 1'b1;
        end else begin
          if (shadow_count == shadow_capacity) shadow_capacity = shadow_capacity << 1;
          shadow_store[shadow_count] = r.push_value;
          shadow_count++;
        end
        expected_resps.push_back(rs);
      end
      MODE_POP: begin
        if (shadow_count > 0) shadow_count--;
        expected_resps.push_back(rs);
      end
      MODE_FRONT, MODE_BACK: begin
        if (shadow_count > 0) begin
          rs.valid_res = 1'b1;
          rs.value = (r.mode == MODE_FRONT) ? shadow_store[0] : shadow_store[shadow_count-1];
        end
        expected_resps.push_back(rs);
      end
      MODE_CAP: begin
        rs.valid_res = 1'b1;
        rs.value = 32'(shadow_capacity);
        expected_resps.push_back(rs);
      end
      MODE_SIZE: begin
        rs.valid_res = 1'b1;
        rs.value = 32'(shadow_count);
        expected_resps.push_back(rs);
      end
      MODE_ELEM: begin
        if (r.read_index < shadow_count) begin
          rs.valid_res = 1'b1;
          rs.value = shadow_store[r.read_index];
        end
        expected_resps.push_back(rs);
      end
      MODE_SORT: begin
        if (shadow_count == 0) begin
          expected_resps.push_back(rs);
        end else begin
          // Insertion sort on signed words, then stream every entry out.
          for (int i = 1; i < shadow_count; i++) begin
            key = shadow_store[i];
            j = i;
            while (j > 0 && $signed(key) < $signed(shadow_store[j-1])) begin
              shadow_store[j] = shadow_store[j-1];
              j--;
            end
            shadow_store[j] = key;
          end
          for (int i = 0; i < shadow_count; i++) begin
            rs.value = shadow_store[i];
            rs.valid_res = 1'b1;
            rs.last = (i + 1 == shadow_count);
            expected_resps.push_back(rs);
          end
        end
      end
      MODE_REINIT: begin
        shadow_capacity = 8'(cfg_init_capacity);
        if (cfg_fill_on) begin
          n = (cfg_init_capacity > STORE_DEPTH) ? STORE_DEPTH : cfg_init_capacity;
          for (int i = 0; i < n; i++) shadow_store[i] = cfg_fill_value;
          shadow_count = n;
        end else begin
          shadow_count = 0;
        end
        expected_resps.push_back(rs);
      end
      default: expected_resps.push_back(rs);
    endcase
  endtask

  // Acceptance is recorded at the rising edge, since the block's ready has
  // already dropped by the following falling edge.
  bit req_taken;
  always @(posedge clk) req_taken <= !rst && s_axis_tvalid && s_axis_tready;

  // Driver: presents queued requests at the falling edge and predicts on acceptance.
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) begin
        predict_stack(pending_reqs.pop_front());
      end
      if (!s_axis_tvalid || req_taken) begin
        if (pending_reqs.size() > 0 &&
            !(sender_idle_allowed && $urandom_range(99) < 30)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, pending_reqs[0].read_index, pending_reqs[0].push_value,
                           pending_reqs[0].mode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !(sink_stall_allowed && $urandom_range(99) < 30);
    end
  end

  // Monitor: compares each delivered result with the oldest expectation.
  always @(posedge clk) begin
    stack_resp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result: value %0h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_resps.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.valid_res) begin
          $error("valid_res: expected %0b, got %0b", want.valid_res, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tuser[1] !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, m_axis_tuser[1]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  task automatic queue_req(input logic [3:0] m, input logic [31:0] v, input logic [5:0] idx);
    pending_reqs.push_back('{mode: m, push_value: v, read_index: idx});
  endtask

  // Waits until every queued request is taken and every result has been seen,
  // then lets the block settle before a register write.
  task automatic drain_block();
    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (expected_resps.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INIT_CAP: cfg_init_capacity = data[6:0];
      REG_FILL_ON:  cfg_fill_on = data[0];
      default:      cfg_fill_value = data;
    endcase
  endtask

  // A random request: mostly pushes and reads, with sorts and reinits now and then.
  function automatic stack_req_t random_req();
    stack_req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.push_value = $urandom();
    r.read_index = $urandom_range(63);
    if (pick < 40) r.mode = MODE_PUSH;
    else if (pick < 50) r.mode = MODE_POP;
    else if (pick < 85) r.mode = 4'($urandom_range(MODE_FRONT, MODE_ELEM));
    else if (pick < 91) r.mode = MODE_SORT;
    else if (pick < 95) r.mode = MODE_REINIT;
    else r.mode = 4'($urandom_range(9, 15));
    return r;
  endfunction

  initial begin
    shadow_count = 0;
    shadow_capacity = 8'd1;
    cfg_init_capacity = 7'd1;
    cfg_fill_on = 1'b0;
    cfg_fill_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty reads, sort of an empty store, growth from one,
    // signed extremes, indices past the size and the unused modes.
    queue_req(MODE_FRONT, '0, '0);
    queue_req(MODE_BACK, '0, '0);
    queue_req(MODE_SORT, '0, '0);
    queue_req(MODE_POP, '0, '0);
    queue_req(MODE_CAP, '0, '0);
    queue_req(MODE_PUSH, 32'h7fffffff, '0);
    queue_req(MODE_PUSH, 32'h80000000, '0);
    queue_req(MODE_PUSH, 32'hffffffff, '0);
    queue_req(MODE_PUSH, 32'h00000000, '0);
    queue_req(MODE_PUSH, 32'h00000001, '0);
    queue_req(MODE_CAP, '0, '0);
    queue_req(MODE_SIZE, '0, '0);
    queue_req(MODE_ELEM, '0, 6'd4);
    queue_req(MODE_ELEM, '0, 6'd5);
    queue_req(MODE_ELEM, '0, 6'd63);
    queue_req(MODE_SORT, '0, '0);
    queue_req(MODE_FRONT, '0, '0);
    queue_req(MODE_BACK, '0, '0);
    queue_req(4'd9, '0, '0);
    queue_req(4'd15, 32'hffffffff, 6'd63);
    queue_req(MODE_REINIT, '0, '0);
    queue_req(MODE_SIZE, '0, '0);
    drain_block();

    // Fill to the limit: overflowing pushes, a full sort, then the largest filling reinit.
    for (int i = 0; i < 66; i++) queue_req(MODE_PUSH, $urandom(), '0);
    queue_req(MODE_CAP, '0, '0);
    queue_req(MODE_SORT, '0, '0);
    drain_block();
    write_reg(REG_INIT_CAP, 32'd127);
    write_reg(REG_FILL_ON, 32'd1);
    write_reg(REG_FILL_VAL, 32'h80000000);
    queue_req(MODE_REINIT, '0, '0);
    queue_req(MODE_CAP, '0, '0);
    queue_req(MODE_SIZE, '0, '0);
    queue_req(MODE_ELEM, '0, 6'd63);
    queue_req(MODE_PUSH, 32'd5, '0);
    drain_block();

    // Zero capacity stays zero when doubled.
    write_reg(REG_INIT_CAP, 32'd0);
    write_reg(REG_FILL_VAL, 32'h7fffffff);
    queue_req(MODE_REINIT, '0, '0);
    queue_req(MODE_PUSH, 32'd3, '0);
    queue_req(MODE_CAP, '0, '0);
    queue_req(MODE_SIZE, '0, '0);
    drain_block();

    // Random phases under several settings; the first runs with no idling at all.
    for (int phase = 0; phase < 5; phase++) begin
      sender_idle_allowed = (phase != 0);
      sink_stall_allowed = (phase != 0);
      write_reg(REG_INIT_CAP, (phase == 4) ? 32'd64 : 32'($urandom_range(1, 20)));
      write_reg(REG_FILL_ON, 32'(phase % 2));
      write_reg(REG_FILL_VAL, $urandom());
      for (int k = 0; k < 42; k++) pending_reqs.push_back(random_req());
      drain_block();
    end

    wait (expected_resps.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("sortable_stack_buffer regression: pass");
    end else begin
      $display("sortable_stack_buffer regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("sortable_stack_buffer regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/ssb_pkg.sv
hw/rtl/sortable_stack_buffer.sv
tb/tb_sortable_stack_buffer.sv
